[hw/rtl/damaged_nonlocal_weight_top_assert.svh]
// Assertion macros for the damaged nonlocal weight block.
// Included by the modules that carry concurrent assertions.
`ifndef DAMAGED_NONLOCAL_WEIGHT_TOP_ASSERT_SVH
`define DAMAGED_NONLOCAL_WEIGHT_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define DNW_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// Next-cycle implication, disabled while reset is active.
`define DNW_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

[hw/rtl/dnw_pkg.sv]
// Shared types and constants of the damaged nonlocal weight block.
// No dependencies.
package dnw_pkg;

    localparam int FRAC_BITS_DEF      = 16;
    localparam int EXPONENT_LIMIT_DEF = 4095;

    localparam int MUL_W = 33;
    localparam int PROD_W = 2 * MUL_W;
    localparam int DIV_W = 57;

    localparam logic [33:0] SQ_THRESH = 34'd1117120993;
    localparam logic [14:0] MILLI_Q24 = 15'd16777;

    // Configuration register indexes.
    localparam logic CFG_INITIAL_RADIUS   = 1'b0;
    localparam logic CFG_RADIUS_TOLERANCE = 1'b1;

    // Request to the fraction divider.
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } div_req_t;

endpackage

[hw/rtl/dnw_mul.sv]
// Shared unsigned multiplier with a registered product.
// Depends on dnw_pkg.
module dnw_mul (
    input  logic                       aclk,
    input  logic [dnw_pkg::MUL_W-1:0]  op_a,
    input  logic [dnw_pkg::MUL_W-1:0]  op_b,
    output logic [dnw_pkg::PROD_W-1:0] prod
);
    import dnw_pkg::*;

    logic [PROD_W-1:0] prod_reg;

    // One product per cycle, available on the following cycle.
    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

[hw/rtl/dnw_div.sv]
// Restoring fraction divider: floor(2^32 * num / den), one bit per cycle.
// Depends on dnw_pkg.
module dnw_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  dnw_pkg::div_req_t req,
    output logic              done,
    output logic [31:0]       quo
);
    import dnw_pkg::*;

    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] den_reg;
    logic [31:0]      quo_reg;
    logic [4:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DIV_W-1:0] rem_sh;

    assign rem_sh = {rem_reg[DIV_W-2:0], 1'b0};

    // Control: a run lasts 32 steps and ends with a one-cycle done.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: one shift, compare and subtract per step.
    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= req.num;
            den_reg <= req.den;
            quo_reg <= '0;
        end else if (busy_reg) begin
            if (rem_sh >= den_reg) begin
                rem_reg <= rem_sh - den_reg;
                quo_reg <= {quo_reg[30:0], 1'b1};
            end else begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

[hw/rtl/damaged_nonlocal_weight_top.sv]
// The sequencer forms the radius products, then n exponent search steps and b weight power
// steps on the shared multiplier, with the ratio and base divisions. A fallback radius adds the
// MLO and MSUM steps; with no power needed the base division and weight steps are skipped; a
// zero radius goes straight to the output. One item at a time: s_tready stays low until the
// result is taken into the output register. Reset (aresetn low, synchronous) idles the sequencer,
// clears the output valid and loads initial_radius = 65536 (1.0 at FRAC_BITS = 16) and radius_tolerance = 1 LSB.
module damaged_nonlocal_weight_top #(
    parameter int FRAC_BITS      = dnw_pkg::FRAC_BITS_DEF,
    parameter int EXPONENT_LIMIT = dnw_pkg::EXPONENT_LIMIT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // distance[23:0], damage[40:24], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // weight[16:0], zero pad
);
    import dnw_pkg::*;

    localparam int DW = (FRAC_BITS + 1 > 17) ? FRAC_BITS + 1 : 17;
    localparam logic [DW-1:0] ONE_D = DW'(1) << FRAC_BITS;
    localparam logic [16:0] LIMIT = 17'(EXPONENT_LIMIT);
    localparam logic [33:0] ROUND_ADD = 34'(1) << (31 - FRAC_BITS);

    localparam logic [4:0] ST_IDLE = 5'd0,  ST_MR2 = 5'd1,  ST_MRT = 5'd2,
                           ST_MRT2 = 5'd3, ST_TOL = 5'd4,  ST_MLO = 5'd5,
                           ST_MSUM = 5'd6, ST_DIVQ = 5'd7, ST_WQ = 5'd8,
                           ST_PM = 5'd9,   ST_PC = 5'd10,  ST_B = 5'd11,
                           ST_R = 5'd12,   ST_WA = 5'd13,  ST_WM = 5'd14,
                           ST_WC = 5'd15,  ST_DONE = 5'd16;

    logic [4:0]  state_reg;
    logic [23:0] rad_reg;
    logic [31:0] tol_reg;
    logic [23:0] r_reg;
    logic [DW-1:0] d_reg;
    logic [47:0] r2big_reg;
    logic [47:0] rt2_reg;
    logic [38:0] tmp_reg;
    logic [32:0] y_reg;
    logic [32:0] p_reg;
    logic [15:0] n_reg;
    logic [16:0] b_reg;
    logic [16:0] k_reg;
    logic [31:0] a_reg;
    logic [32:0] w_reg;
    logic [16:0] wout_reg;
    logic        out_valid_reg;
    logic [16:0] weight_reg;

    logic [MUL_W-1:0]  mul_a;
    logic [MUL_W-1:0]  mul_b;
    logic [PROD_W-1:0] prod;
    div_req_t          div_req;
    logic              div_done;
    logic [31:0]       div_quo;

    logic [DW-1:0] d_in;
    logic [23:0]   rt;
    logic [47:0]   rt2_now;
    logic [33:0]   prod_hi;
    logic [16:0]   b_calc;
    logic [33:0]   w_round;

    dnw_mul u_mul (.aclk(aclk), .op_a(mul_a), .op_b(mul_b), .prod(prod));
    dnw_div u_div (.aclk(aclk), .aresetn(aresetn), .req(div_req), .done(div_done),
                   .quo(div_quo));

    // Input damage, saturated to one.
    always_comb begin
        d_in = DW'(s_tdata[40:24]);
        if (d_in > ONE_D) begin
            d_in = ONE_D;
        end
    end

    assign rt      = 24'(prod >> FRAC_BITS);
    assign rt2_now = prod[47:0];
    assign prod_hi = prod[65:32];
    assign b_calc  = (17'(n_reg) + 17'(n_reg[0]) > LIMIT) ? LIMIT
                     : 17'(n_reg) + 17'(n_reg[0]);
    assign w_round = 34'(w_reg) + ROUND_ADD;

    // Multiplier operand selection by sequencer step.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MR2: begin
                mul_a = MUL_W'(rad_reg);
                mul_b = MUL_W'(rad_reg);
            end
            ST_MRT: begin
                mul_a = MUL_W'(rad_reg);
                mul_b = MUL_W'(ONE_D - d_reg);
            end
            ST_MRT2: begin
                mul_a = MUL_W'(rt);
                mul_b = MUL_W'(rt);
            end
            ST_TOL: begin
                mul_a = MUL_W'(r2big_reg[47:24]);
                mul_b = MUL_W'(MILLI_Q24);
            end
            ST_MLO: begin
                mul_a = MUL_W'(r2big_reg[23:0]);
                mul_b = MUL_W'(MILLI_Q24);
            end
            ST_PM: begin
                mul_a = p_reg;
                mul_b = y_reg;
            end
            ST_B: begin
                mul_a = MUL_W'(r_reg);
                mul_b = MUL_W'(r_reg);
            end
            ST_WM: begin
                mul_a = w_reg;
                mul_b = MUL_W'(a_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Divider requests: ratio term and distance base.
    always_comb begin
        div_req.start = 1'b0;
        div_req.num   = '0;
        div_req.den   = '0;
        if (state_reg == ST_DIVQ) begin
            div_req.start = 1'b1;
            div_req.num   = (DIV_W'(rt2_reg) << 5) + (DIV_W'(rt2_reg) << 4)
                            + DIV_W'(rt2_reg);
            div_req.den   = (DIV_W'(r2big_reg) << 6) + (DIV_W'(r2big_reg) << 5)
                            + (DIV_W'(r2big_reg) << 2);
        end else if (state_reg == ST_R && prod[47:0] < r2big_reg && prod[47:0] != 48'd0
                     && b_reg != 17'd0) begin
            div_req.start = 1'b1;
            div_req.num   = DIV_W'(r2big_reg - prod[47:0]);
            div_req.den   = DIV_W'(r2big_reg);
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rad_reg <= 24'(65536);
            tol_reg <= 32'd1;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_INITIAL_RADIUS:   rad_reg <= cfg_wdata[23:0];
                CFG_RADIUS_TOLERANCE: tol_reg <= cfg_wdata;
                default:              rad_reg <= rad_reg;
            endcase
        end
    end

    // Sequencer control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            // The held item leaves on its handshake; the final step sets valid on its own.
            if (out_valid_reg && m_tready && state_reg != ST_DONE) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= (rad_reg == 24'd0) ? ST_DONE : ST_MR2;
                    end
                end
                ST_MR2:  state_reg <= ST_MRT;
                ST_MRT:  state_reg <= ST_MRT2;
                ST_MRT2: state_reg <= ST_TOL;
                ST_TOL:  state_reg <= (rt2_now < 48'(tol_reg)) ? ST_MLO : ST_DIVQ;
                ST_MLO:  state_reg <= ST_MSUM;
                ST_MSUM: state_reg <= ST_DIVQ;
                ST_DIVQ: state_reg <= ST_WQ;
                ST_WQ: begin
                    if (div_done) begin
                        state_reg <= (div_quo == 32'd0) ? ST_B : ST_PM;
                    end
                end
                ST_PM:   state_reg <= (17'(n_reg) < LIMIT) ? ST_PC : ST_B;
                ST_PC:   state_reg <= (prod_hi < SQ_THRESH) ? ST_B : ST_PM;
                ST_B:    state_reg <= ST_R;
                ST_R:    state_reg <= div_req.start ? ST_WA : ST_DONE;
                ST_WA: begin
                    if (div_done) begin
                        state_reg <= ST_WM;
                    end
                end
                ST_WM: begin
                    state_reg <= (k_reg < b_reg && w_reg != 33'd0) ? ST_WC : ST_DONE;
                end
                ST_WC:   state_reg <= ST_WM;
                ST_DONE: begin
                    if (!out_valid_reg || m_tready) begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Sequencer datapath.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                r_reg    <= s_tdata[23:0];
                d_reg    <= d_in;
                wout_reg <= '0;
            end
            ST_MRT:  r2big_reg <= prod[47:0];
            ST_TOL:  rt2_reg   <= rt2_now;
            ST_MLO:  tmp_reg   <= prod[38:0];
            ST_MSUM: rt2_reg   <= 48'(tmp_reg) + 48'(prod[47:24]);
            ST_WQ: begin
                y_reg <= (33'(1) << 32) - 33'(div_quo);
                p_reg <= 33'(1) << 32;
                n_reg <= (div_quo == 32'd0) ? 16'(EXPONENT_LIMIT) : 16'd0;
            end
            ST_PC: begin
                if (prod_hi >= SQ_THRESH) begin
                    p_reg <= 33'(prod_hi);
                    n_reg <= n_reg + 16'd1;
                end
            end
            ST_B:    b_reg <= b_calc;
            ST_R: begin
                if (b_reg == 17'd0 || prod[47:0] == 48'd0) begin
                    wout_reg <= 17'(DW'(1) << FRAC_BITS);
                end else begin
                    wout_reg <= '0;
                end
            end
            ST_WA: begin
                a_reg <= div_quo;
                w_reg <= 33'(1) << 32;
                k_reg <= '0;
            end
            ST_WM: begin
                if (!(k_reg < b_reg && w_reg != 33'd0)) begin
                    wout_reg <= 17'(w_round >> (32 - FRAC_BITS));
                end
            end
            ST_WC: begin
                w_reg <= 33'(prod_hi);
                k_reg <= k_reg + 17'd1;
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    weight_reg <= wout_reg;
                end
            end
            default: begin
                r_reg <= r_reg;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, weight_reg};

    `include "damaged_nonlocal_weight_top_assert.svh"

    `DNW_ASSERT_NEXT(a_accept_leaves_idle, aclk, aresetn, s_tvalid && s_tready, state_reg != ST_IDLE)
    `DNW_ASSERT_IMPLY(a_pc_after_pm, aclk, aresetn, state_reg == ST_PC, $past(state_reg) == ST_PM)
    `DNW_ASSERT_IMPLY(a_n_bounded, aclk, aresetn, state_reg == ST_B, 17'(n_reg) <= LIMIT)
    `DNW_ASSERT_IMPLY(a_k_bounded, aclk, aresetn, state_reg == ST_WM, k_reg <= b_reg)

endmodule
